[sv/pnor_pkg.sv]
// Package for the pink noise octave rows unit.
// Holds the fixed widths and the gain reset value used by the top-level design file.
// No dependencies.
`timescale 1ns / 1ps

package pnor_pkg;

    // Wrapping tick counter width.
    localparam int TICK_W = 16;

    // Gain register: unsigned Q8.8, unity at reset.
    localparam int GAIN_W = 16;
    localparam int GAIN_FRAC = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

endpackage

[sv/pink_noise_octave_rows_unit.sv]
// Pink noise generator over octave rows, top level.
// Depends on pnor_pkg for the counter and gain widths.
// The checker in pnor_checker.sv binds onto this module.
`timescale 1ns / 1ps

// One white sample is accepted per transfer and one pink sample is produced for it.
// The unit accepts a new sample in every clock cycle unless output back-pressure
// holds it; the result passes through a six-register pipeline that stalls only where
// a result is waiting and the stages behind it are full. The row update rewrites
// all octave prefix sums at once. The output is the sum of the rows times the Q8.8
// gain, divided by the octave count times 256 with truncation toward zero, and
// saturated to the sample width.

module pink_noise_octave_rows_unit
    import pnor_pkg::*;
#(
    parameter int OCTAVES     = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Gain configuration
    input  logic                          i_gain_we,
    input  logic [GAIN_W-1:0]             i_gain_wdata,
    // White sample input channel
    input  logic                          i_white_valid,
    output logic                          o_white_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_white_sample,
    // Pink sample output channel
    output logic                          o_pink_valid,
    input  logic                          i_pink_ready,
    output logic signed [SAMPLE_BITS-1:0] o_pink_sample
);

    // Derived widths.
    localparam int ROW_W  = SAMPLE_BITS - 1;
    localparam int SUM_W  = ROW_W + $clog2(OCTAVES);
    localparam int K_W    = $clog2(OCTAVES + 1);
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int MAG_W  = PROD_W - GAIN_FRAC;
    localparam int Q_N    = SAMPLE_BITS + $clog2(OCTAVES);
    localparam int SH_L   = $clog2(OCTAVES);
    localparam int SH_S   = Q_N + SH_L;
    localparam int MUL_W  = 2 * Q_N + 1;

    // Magnitudes beyond this value saturate anyway.
    localparam logic [MAG_W-1:0] MAG_CLAMP =
        MAG_W'(OCTAVES) << (SAMPLE_BITS - 1);
    // Reciprocal of the octave count, exact for magnitudes below 2^Q_N.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH_S) + 64'(OCTAVES) - 64'd1) / 64'(OCTAVES);
    localparam logic [Q_N:0] RECIP = RECIP_FULL[Q_N:0];

    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // Registers.
    logic [GAIN_W-1:0]             r_gain;
    logic [TICK_W-1:0]             r_tick;
    logic signed [SUM_W-1:0]       r_prefix [1:OCTAVES];

    logic                          r_v1, r_v2, r_v3, r_v4, r_v5, r_out_v;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [PROD_W-1:0]      r_prod;
    logic [Q_N-1:0]                r_mag;
    logic                          r_neg4, r_neg5;
    logic [MUL_W-1:0]              r_mul;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    // Stage enables: a stage moves when it is empty or the one after it moves.
    logic en_out, en5, en4, en3, en2, en1;

    assign en_out = !r_out_v || i_pink_ready;
    assign en5    = !r_v5 || en_out;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;

    assign o_white_ready = en1;
    assign o_pink_valid  = r_out_v;
    assign o_pink_sample = r_out_sample;

    // Row update: the refreshed rows always form a prefix 0..k-1, so each prefix sum
    // is either j*h or its old value shifted by the change in the first k rows.
    logic [TICK_W-1:0]       n_tick;
    logic signed [SUM_W-1:0] half_ext;
    logic [OCTAVES-1:0]      refresh;
    logic [K_W-1:0]          k_cnt;
    logic signed [SUM_W-1:0] lane_jh [1:OCTAVES];
    logic signed [SUM_W-1:0] k_h;
    logic signed [SUM_W-1:0] k_old;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] n_prefix [1:OCTAVES];

    always_comb begin
        n_tick   = r_tick + TICK_W'(1);
        half_ext = SUM_W'($signed(r_in_sample[SAMPLE_BITS-1:1]));
        refresh  = '0;
        refresh[0] = 1'b1;
        for (int i = 1; i < OCTAVES; i++) begin
            refresh[i] = ((n_tick & ((TICK_W'(1) << i) - TICK_W'(1))) == '0);
        end
        k_cnt = K_W'($countones(refresh));
        k_h   = '0;
        k_old = '0;
        for (int j = 1; j <= OCTAVES; j++) begin
            lane_jh[j] = SUM_W'($signed(SUM_W'(j)) * half_ext);
            if (k_cnt == K_W'(j)) begin
                k_h   = lane_jh[j];
                k_old = r_prefix[j];
            end
        end
        delta = k_h - k_old;
        for (int j = 1; j <= OCTAVES; j++) begin
            if (refresh[j-1]) begin
                n_prefix[j] = lane_jh[j];
            end else begin
                n_prefix[j] = r_prefix[j] + delta;
            end
        end
    end

    // Gain register and row state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_tick <= '0;
            for (int j = 1; j <= OCTAVES; j++) begin
                r_prefix[j] <= '0;
            end
        end else begin
            if (i_gain_we) begin
                r_gain <= i_gain_wdata;
            end
            if (r_v1 && en2) begin
                r_tick <= n_tick;
                for (int j = 1; j <= OCTAVES; j++) begin
                    r_prefix[j] <= n_prefix[j];
                end
            end
        end
    end

    // Magnitude of the scaled sum, floored by 256 and clamped.
    logic [PROD_W-1:0] prod_abs;
    logic [MAG_W-1:0]  mag_full;
    logic [Q_N-1:0]    n_mag;

    always_comb begin
        prod_abs = r_prod[PROD_W-1] ? (~r_prod + PROD_W'(1)) : r_prod;
        mag_full = prod_abs[PROD_W-1:GAIN_FRAC];
        if (mag_full > MAG_CLAMP) begin
            n_mag = MAG_CLAMP[Q_N-1:0];
        end else begin
            n_mag = mag_full[Q_N-1:0];
        end
    end

    // Quotient by the octave count, then sign and saturation.
    logic [SAMPLE_BITS-1:0]        quot;
    logic signed [SAMPLE_BITS-1:0] n_out_sample;

    always_comb begin
        quot = r_mul[SH_S +: SAMPLE_BITS];
        if (r_neg5) begin
            n_out_sample = $signed(~quot + SAMPLE_BITS'(1));
        end else if (quot[SAMPLE_BITS-1]) begin
            n_out_sample = OUT_MAX;
        end else begin
            n_out_sample = $signed(quot);
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en1)    r_v1    <= i_white_valid;
            if (en2)    r_v2    <= r_v1;
            if (en3)    r_v3    <= r_v2;
            if (en4)    r_v4    <= r_v3;
            if (en5)    r_v5    <= r_v4;
            if (en_out) r_out_v <= r_v5;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_in_sample <= i_white_sample;
        end
        if (en2) begin
            r_sum <= n_prefix[OCTAVES];
        end
        if (en3) begin
            r_prod <= r_sum * $signed({1'b0, r_gain});
        end
        if (en4) begin
            r_mag  <= n_mag;
            r_neg4 <= r_prod[PROD_W-1];
        end
        if (en5) begin
            r_mul  <= MUL_W'(r_mag) * MUL_W'(RECIP);
            r_neg5 <= r_neg4;
        end
        if (en_out) begin
            r_out_sample <= n_out_sample;
        end
    end

endmodule

[sv/pnor_checker.sv]
// Port-level checker for the pink noise octave rows unit.
// Sees only the top-level ports; bound to pink_noise_octave_rows_unit below.
`timescale 1ns / 1ps

module pnor_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_white_ready,
    input logic                   o_pink_valid,
    input logic                   i_pink_ready,
    input logic [SAMPLE_BITS-1:0] o_pink_sample
);

    // A stalled result holds its value until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pink_valid && !i_pink_ready |=> o_pink_valid && $stable(o_pink_sample))
        else $error("pink sample changed while stalled");

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pink_valid)
        else $error("result valid straight after reset");

    // With the output register empty the pipeline cannot be blocked.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pink_valid |-> o_white_ready)
        else $error("input not ready with empty output");

    // Back-pressure comes only from the output side.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pink_ready |-> o_white_ready)
        else $error("input stalled while output is taken");

endmodule

bind pink_noise_octave_rows_unit pnor_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_pnor_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_white_ready (o_white_ready),
    .o_pink_valid  (o_pink_valid),
    .i_pink_ready  (i_pink_ready),
    .o_pink_sample (o_pink_sample)
);
